[rtl/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

[rtl/ple_pkg.sv]
package ple_pkg;

    // fixed field widths
    localparam int CMD_W = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_GET     = 3'd2,
        CMD_SET     = 3'd3,
        CMD_REVERSE = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } t_state;

    // what each cell does with its entry this cycle
    typedef enum logic [1:0] {
        EOP_HOLD,
        EOP_INS,
        EOP_DEL,
        EOP_SET
    } t_entry_op;

    typedef struct packed {
        t_entry_op op;
        logic      tap_load;
        logic      tap_shift;
    } t_cell_ctl;

endpackage

[rtl/positional_list_engine.sv]
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------------
// command   | i_command, i_position, i_value            | start high, busy low
// result    | o_status, o_read_value, o_length          | o_done high for one cycle
//
// insert, remove, set, reverse, clear and bad commands give their result in the cycle
// after the beat; a new beat may be taken in that same result cycle.
// a get of physical slot q loads the read tap chain, which then moves the entry
// one cell per cycle toward slot zero; busy is high meanwhile.
// reverse flips an orientation flag, so positions map to slots from either end.
// reset (i_rst_n low, synchronous) empties the list; entry contents are kept.
// the receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] i_command,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_done,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_read_value,
    output logic [LEN_W-1:0] o_length
);

    localparam int IW = $clog2(DEPTH);

    t_cell_ctl        w_ctl;
    logic [IW-1:0]    w_q;
    logic [VAL_W-1:0] w_entry [DEPTH];
    logic [VAL_W-1:0] w_tap   [DEPTH];

    // command control, counting and result
    ple_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_tap0      (w_tap[0]),
        .o_ctl       (w_ctl),
        .o_q         (w_q),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_read_value(o_read_value),
        .o_length    (o_length)
    );

    // row of entry cells, each linked to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        logic [VAL_W-1:0] w_tap_next;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right    = w_entry[g];
            assign w_tap_next = '0;
        end else begin : g_inner
            assign w_right    = w_entry[g+1];
            assign w_tap_next = w_tap[g+1];
        end

        ple_cell #(
            .IW (IW),
            .IDX(g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_q       (w_q),
            .i_value   (i_value),
            .i_left    (w_left),
            .i_right   (w_right),
            .i_tap_next(w_tap_next),
            .o_entry   (w_entry[g]),
            .o_tap     (w_tap[g])
        );
    end

endmodule

[rtl/ple_cell.sv]
module ple_cell
    import ple_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IW-1:0]    i_q,
    input  logic [VAL_W-1:0] i_value,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    input  logic [VAL_W-1:0] i_tap_next,
    output logic [VAL_W-1:0] o_entry,
    output logic [VAL_W-1:0] o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic [VAL_W-1:0] r_tap;

    // entry update: shift back, close gap or overwrite
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            EOP_INS: begin
                if (MY_IDX > i_q) begin
                    n_entry = i_left;
                end else if (MY_IDX == i_q) begin
                    n_entry = i_value;
                end
            end
            EOP_DEL: begin
                if (MY_IDX >= i_q) begin
                    n_entry = i_right;
                end
            end
            EOP_SET: begin
                if (MY_IDX == i_q) begin
                    n_entry = i_value;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // read tap: parallel load, then shift toward slot zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.tap_load) begin
            r_tap <= r_entry;
        end else if (i_ctl.tap_shift) begin
            r_tap <= i_tap_next;
        end
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;

endmodule

[rtl/ple_ctrl.sv]
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_command,
    input  logic [POS_W-1:0]           i_position,
    input  logic [VAL_W-1:0]           i_tap0,
    output t_cell_ctl                  o_ctl,
    output logic [$clog2(DEPTH)-1:0]   o_q,
    output logic                       o_done,
    output logic [ST_W-1:0]            o_status,
    output logic [VAL_W-1:0]           o_read_value,
    output logic [LEN_W-1:0]           o_length
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_rev;
    logic          n_rev;
    t_status       r_status;
    t_status       n_status;
    logic          r_is_get;
    logic          n_is_get;
    logic [IW-1:0] r_wait;
    logic [IW-1:0] n_wait;

    logic          accept;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic          pos_zero;
    logic          ins_bad;
    logic          held_bad;
    logic          full;
    logic [IW-1:0] q_ins;
    logic [IW-1:0] q_held;
    logic          get_go;

    assign accept = start && !busy;
    assign pos_x  = PW'(i_position);
    assign cnt_x  = PW'(r_count);

    // range checks against the current count
    assign pos_zero = (pos_x == '0);
    assign ins_bad  = pos_zero || (pos_x > cnt_x + PW'(1));
    assign held_bad = pos_zero || (pos_x > cnt_x);
    assign full     = (cnt_x == PW'(DEPTH));

    // logical position to slot, mirrored when the order flag is set
    assign q_ins  = r_rev ? IW'(cnt_x + PW'(1) - pos_x) : IW'(pos_x - PW'(1));
    assign q_held = r_rev ? IW'(cnt_x - pos_x) : IW'(pos_x - PW'(1));

    assign get_go = accept && (t_cmd'(i_command) == CMD_GET) && !held_bad;

    // command decode and datapath updates
    always_comb begin
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = r_status;
        n_is_get = r_is_get;
        n_wait   = r_wait;
        o_ctl    = '{op: EOP_HOLD, tap_load: 1'b0, tap_shift: 1'b0};
        o_q      = q_held;
        if (accept) begin
            n_status = ST_DONE;
            n_is_get = 1'b0;
            case (t_cmd'(i_command))
                CMD_INSERT: begin
                    o_q = q_ins;
                    if (ins_bad) begin
                        n_status = ST_BADPOS;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.op = EOP_INS;
                        n_count  = r_count + CW'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (held_bad) begin
                        n_status = ST_BADPOS;
                    end else begin
                        o_ctl.op = EOP_DEL;
                        n_count  = r_count - CW'(1);
                    end
                end
                CMD_GET: begin
                    if (held_bad) begin
                        n_status = ST_BADPOS;
                    end else begin
                        o_ctl.tap_load = 1'b1;
                        n_wait         = q_held;
                        n_is_get       = 1'b1;
                    end
                end
                CMD_SET: begin
                    if (held_bad) begin
                        n_status = ST_BADPOS;
                    end else begin
                        o_ctl.op = EOP_SET;
                    end
                end
                CMD_REVERSE: begin
                    n_rev = !r_rev;
                end
                CMD_CLEAR: begin
                    n_count = '0;
                    n_rev   = 1'b0;
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end else if (r_state == S_SHIFT) begin
            o_ctl.tap_shift = 1'b1;
            n_wait          = r_wait - IW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE, S_DONE: begin
                if (get_go && (q_held != '0)) begin
                    n_state = S_SHIFT;
                end else if (accept) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (r_wait == IW'(1)) begin
                    n_state = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy         = (r_state == S_SHIFT);
        o_done       = (r_state == S_DONE);
        o_status     = r_status;
        o_read_value = r_is_get ? i_tap0 : '0;
        o_length     = cnt_x[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_is_get <= n_is_get;
        r_wait   <= n_wait;
    end

endmodule

[rtl/ple_checker.sv]
`include "assert_macros.svh"

module ple_checker
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [CMD_W-1:0] i_command,
    input logic             o_done,
    input logic [ST_W-1:0]  o_status,
    input logic [VAL_W-1:0] o_read_value,
    input logic [LEN_W-1:0] o_length
);

    // a taken beat gives its result next cycle or holds busy
    `ASSERT_NEXT(a_beat_progress, start && !busy, o_done || busy, "beat neither done nor busy")

    // a busy stretch ends only in a result
    `ASSERT_NEXT(a_busy_ends_done, busy, o_done || busy, "busy dropped without a result")

    // failed commands return no read data
    `ASSERT_SAME(a_fail_zero_read, o_done && (o_status != ST_DONE), o_read_value == '0,
        "read value nonzero on failed command")

    // clear leaves an empty list
    `ASSERT_SAME(a_clear_empty, o_done && $past(start && !busy && (i_command == CMD_CLEAR)),
        o_length == '0, "length nonzero after clear")

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);

[dv/positional_list_engine_tb.sv]
`timescale 1ns / 1ps

module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               gap;
    } t_list_cmd;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] length;
    } t_list_result;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] i_command    = '0;
    logic [POS_W-1:0] i_position   = '0;
    logic [VAL_W-1:0] i_value      = '0;
    logic             o_done;
    logic [ST_W-1:0]  o_status;
    logic [VAL_W-1:0] o_read_value;
    logic [LEN_W-1:0] o_length;

    positional_list_engine #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_read_value(o_read_value),
        .o_length    (o_length)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_list_cmd    cmd_backlog[$];
    t_list_result result_due[$];
    int           fail_cnt = 0;
    int           cycle_cnt = 0;

    // shadow of the list contents
    logic [VAL_W-1:0] list_vals[DEPTH];
    int               list_len = 0;

    // stimulus-side tracking of the list length
    int gen_len = 0;

    // apply one command to the shadow list and return the expected beat
    function automatic t_list_result apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [POS_W-1:0] pos_bits,
                                                   input logic [VAL_W-1:0] val);
        t_list_result res;
        logic [VAL_W-1:0] tmp;
        int pos;
        int i;
        pos = int'(pos_bits);
        res.status     = ST_DONE;
        res.read_value = '0;
        case (cmd)
            CMD_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    res.status = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos - 1; i--) list_vals[i] = list_vals[i-1];
                    list_vals[pos-1] = val;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (pos < 1 || pos > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = pos - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            CMD_GET: begin
                if (pos < 1 || pos > list_len) res.status = ST_BADPOS;
                else res.read_value = list_vals[pos-1];
            end
            CMD_SET: begin
                if (pos < 1 || pos > list_len) res.status = ST_BADPOS;
                else list_vals[pos-1] = val;
            end
            CMD_REVERSE: begin
                for (i = 0; i < list_len / 2; i++) begin
                    tmp                     = list_vals[i];
                    list_vals[i]            = list_vals[list_len-1-i];
                    list_vals[list_len-1-i] = tmp;
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    // queue one command and keep the stimulus-side length in step
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                             input logic [VAL_W-1:0] val, input bit no_idle);
        t_list_cmd item;
        item.cmd = cmd;
        item.pos = POS_W'(pos);
        item.val = val;
        item.gap = no_idle ? 0 : $urandom_range(0, 10);
        cmd_backlog.push_back(item);
        case (cmd)
            CMD_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH) gen_len++;
            CMD_REMOVE: if (pos >= 1 && pos <= gen_len) gen_len--;
            CMD_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = 32'h0000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h8000_0000;
            3:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // driver: one beat per handshake, random idle cycles between beats
    logic      staged = 1'b0;
    t_list_cmd staged_item;
    int        wait_left = 0;

    always @(posedge i_clk) begin : drv_proc
        t_list_cmd nxt;
        bit fetch;
        bit load;
        fetch = 1'b0;
        load  = 1'b0;
        if (!i_rst_n) begin
            start     <= 1'b0;
            staged    <= 1'b0;
            wait_left <= 0;
        end else begin
            if (start && !busy) begin
                result_due.push_back(apply_command(i_command, i_position, i_value));
                fetch = 1'b1;
            end else if (!start && staged) begin
                if (wait_left == 0) begin
                    nxt    = staged_item;
                    load   = 1'b1;
                    staged <= 1'b0;
                end else begin
                    wait_left <= wait_left - 1;
                end
            end else if (!start) begin
                fetch = 1'b1;
            end

            if (fetch && cmd_backlog.size() != 0) begin
                nxt = cmd_backlog.pop_front();
                if (nxt.gap == 0) begin
                    load = 1'b1;
                end else begin
                    staged_item <= nxt;
                    staged      <= 1'b1;
                    wait_left   <= nxt.gap - 1;
                end
            end

            if (load) begin
                i_command  <= nxt.cmd;
                i_position <= nxt.pos;
                i_value    <= nxt.val;
                start      <= 1'b1;
            end else if (start && !busy) begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : mon_proc
        t_list_result want;
        if (i_rst_n && o_done) begin
            if (result_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("unexpected result beat: status=%0d read=%h length=%0d",
                             o_status, o_read_value, o_length);
            end else begin
                want = result_due.pop_front();
                if (o_status !== want.status || o_read_value !== want.read_value ||
                    o_length !== want.length) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display({"mismatch: exp status=%0d read=%h length=%0d, ",
                                  "got status=%0d read=%h length=%0d"},
                                 want.status, want.read_value, want.length,
                                 o_status, o_read_value, o_length);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stim_proc
        logic [CMD_W-1:0] cmd;
        int  r;
        int  pos;
        int  valid_hi;
        bit  filling;
        bit  no_idle;

        // directed: empty list, bad positions, extremes, reverse, spare codes
        queue_cmd(CMD_GET,     1, 32'h0,         1'b0);
        queue_cmd(CMD_REMOVE,  1, 32'h0,         1'b0);
        queue_cmd(CMD_SET,     1, 32'h1234_5678, 1'b0);
        queue_cmd(CMD_INSERT,  0, 32'h1,         1'b0);
        queue_cmd(CMD_INSERT,  2, 32'h2,         1'b0);
        queue_cmd(CMD_INSERT,  1, 32'h7fff_ffff, 1'b0);
        queue_cmd(CMD_INSERT,  2, 32'h8000_0000, 1'b1);
        queue_cmd(CMD_INSERT,  1, 32'hffff_ffff, 1'b1);
        queue_cmd(CMD_INSERT,  4, 32'h0,         1'b0);
        queue_cmd(CMD_GET,     1, 32'h0,         1'b1);
        queue_cmd(CMD_GET,     4, 32'h0,         1'b0);
        queue_cmd(CMD_GET,     5, 32'h0,         1'b0);
        queue_cmd(CMD_SET,     2, 32'h5a5a_5a5a, 1'b0);
        queue_cmd(CMD_REVERSE, 0, 32'hffff_ffff, 1'b1);
        queue_cmd(CMD_GET,     1, 32'h0,         1'b1);
        queue_cmd(CMD_GET,     3, 32'h0,         1'b0);
        queue_cmd(CMD_REMOVE,  4, 32'h0,         1'b0);
        queue_cmd(CMD_REMOVE,  1, 32'h0,         1'b0);
        queue_cmd(CMD_SPARE_LO, 31, $urandom,     1'b0);
        queue_cmd(CMD_SPARE_HI, 0, 32'hffff_ffff, 1'b1);
        queue_cmd(CMD_GET,     31, 32'h0,        1'b0);
        queue_cmd(CMD_CLEAR,   31, 32'hffff_ffff, 1'b0);
        queue_cmd(CMD_REVERSE, 17, 32'h0,        1'b0);
        queue_cmd(CMD_INSERT,  31, 32'h55aa_55aa, 1'b0);

        // random: alternate fill and drain phases so the list swings full and empty
        for (int n = 0; n < RAND_ITEMS; n++) begin
            filling = ((n / 40) % 2) == 0;
            no_idle = ((n / 50) % 3) == 2;
            r = $urandom_range(0, 99);
            if (filling) begin
                if      (r < 50) cmd = CMD_INSERT;
                else if (r < 62) cmd = CMD_REMOVE;
                else if (r < 78) cmd = CMD_GET;
                else if (r < 89) cmd = CMD_SET;
                else if (r < 95) cmd = CMD_REVERSE;
                else if (r < 97) cmd = CMD_CLEAR;
                else             cmd = (r == 99) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end else begin
                if      (r < 15) cmd = CMD_INSERT;
                else if (r < 55) cmd = CMD_REMOVE;
                else if (r < 75) cmd = CMD_GET;
                else if (r < 87) cmd = CMD_SET;
                else if (r < 94) cmd = CMD_REVERSE;
                else if (r < 96) cmd = CMD_CLEAR;
                else             cmd = (r >= 98) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end
            // mostly legal positions, some anywhere in the field
            valid_hi = (cmd == CMD_INSERT) ? gen_len + 1 : gen_len;
            if (valid_hi == 0 || $urandom_range(0, 9) == 0) pos = $urandom_range(0, 31);
            else pos = $urandom_range(1, valid_hi);
            queue_cmd(cmd, pos, pick_value(), no_idle);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything sent and answered, then allow for the slowest get
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || staged || start || result_due.size() != 0);
        repeat (DEPTH + 4) @(posedge i_clk);

        if (fail_cnt == 0 && result_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[positional_list_engine.f]
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
rtl/ple_checker.sv
dv/positional_list_engine_tb.sv
